// File: hdl/qtl_pkg.sv
`timescale 1ns / 1ps

package qtl_pkg;

    typedef enum logic [2:0] {
        KIND_BYTE = 3'd0,
        KIND_END  = 3'd1,
        KIND_DROP = 3'd2,
        KIND_OK   = 3'd3,
        KIND_ERR  = 3'd4
    } kind_t;

    // One result beat as it sits in the output queue.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] tok_byte;
        logic       last;
    } result_t;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    localparam logic [7:0] CHAR_HASH      = 8'h23;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] CHAR_EQUALS    = 8'h3D;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_MINUS     = 8'h2D;
    localparam logic [7:0] CHAR_UNDER     = 8'h5F;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    // Output queue: room for two full items' worth of results.
    localparam int OutDepth = 4;

    function automatic logic is_word_char(input logic [7:0] c);
        is_word_char = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39) ||
                       (c >= 8'h61 && c <= 8'h7A) || c == CHAR_DOT || c == CHAR_COLON ||
                       c == CHAR_EQUALS || c == CHAR_SLASH || c == CHAR_MINUS ||
                       c == CHAR_UNDER;
    endfunction

    function automatic logic is_blank_char(input logic [7:0] c);
        is_blank_char = c == CHAR_SPACE || c == CHAR_LF || c == CHAR_TAB || c == CHAR_CR;
    endfunction

endpackage

// File: hdl/quoted_token_lexer_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_command, s_char_code
// m_       out        m_valid / m_ready   m_kind, m_token_byte, m_last
//
// A beat taken on s_ is held in an input register and lexed once the output
// queue has room for two results; its results land in that four-entry queue.
// One input beat per cycle is taken while the queue holds two or fewer
// results; an end-of-line beat gives up to two results, which leave one per
// cycle while m_ready is high. Reset (aresetn low at a clock edge) empties
// the queue and returns the lexer to blank mode with no error.
// Back-pressure on m_ fills the queue and then holds s_ready low.

module quoted_token_lexer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_char_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_token_byte,
    output logic       m_last
);

    logic             in_vld_reg;
    logic             in_vld_next;
    logic             in_cmd_reg;
    logic [7:0]       in_char_reg;
    logic             room_for_two;
    logic             consume;
    logic [1:0]       res_cnt;
    qtl_pkg::result_t res0;
    qtl_pkg::result_t res1;
    qtl_pkg::result_t head;

    assign consume = in_vld_reg && room_for_two;
    assign s_ready = !in_vld_reg || room_for_two;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (consume) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_command;
            in_char_reg <= s_char_code;
        end
    end

    qtl_lex u_lex (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (consume),
        .command   (in_cmd_reg),
        .char_code (in_char_reg),
        .res_cnt   (res_cnt),
        .res0      (res0),
        .res1      (res1)
    );

    qtl_out_fifo u_out_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_cnt     (res_cnt),
        .push0        (res0),
        .push1        (res1),
        .pop          (m_ready),
        .not_empty    (m_valid),
        .room_for_two (room_for_two),
        .head         (head)
    );

    assign m_kind       = head.kind;
    assign m_token_byte = head.tok_byte;
    assign m_last       = head.last;

endmodule

// File: hdl/qtl_lex.sv
`timescale 1ns / 1ps

module qtl_lex (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_fire,
    input  logic              command,
    input  logic [7:0]        char_code,
    output logic [1:0]        res_cnt,
    output qtl_pkg::result_t  res0,
    output qtl_pkg::result_t  res1
);

    typedef enum logic [2:0] {
        MODE_BLANK   = 3'd0,
        MODE_WORD    = 3'd1,
        MODE_QUOTED  = 3'd2,
        MODE_ESCAPE  = 3'd3,
        MODE_COMMENT = 3'd4
    } mode_t;

    typedef struct packed {
        mode_t          mode;
        logic           err;
        logic           emit;
        qtl_pkg::kind_t kind;
        logic [7:0]     tok;
    } byte_step_t;

    mode_t mode_reg;
    mode_t mode_next;
    logic  err_reg;
    logic  err_next;

    function automatic byte_step_t step_byte(input mode_t m, input logic [7:0] c);
        byte_step_t s;
        s.mode = m;
        s.err  = 1'b0;
        s.emit = 1'b0;
        s.kind = qtl_pkg::KIND_BYTE;
        s.tok  = 8'h00;
        case (m)
            MODE_WORD: begin
                if (qtl_pkg::is_word_char(c)) begin
                    s.emit = 1'b1;
                    s.tok  = c;
                end else if (qtl_pkg::is_blank_char(c)) begin
                    s.emit = 1'b1;
                    s.kind = qtl_pkg::KIND_END;
                    s.mode = MODE_BLANK;
                end else if (c == qtl_pkg::CHAR_HASH) begin
                    s.emit = 1'b1;
                    s.kind = qtl_pkg::KIND_DROP;
                    s.mode = MODE_COMMENT;
                end else begin
                    s.err = 1'b1;
                end
            end
            MODE_QUOTED: begin
                if (c == qtl_pkg::CHAR_QUOTE) begin
                    s.emit = 1'b1;
                    s.kind = qtl_pkg::KIND_END;
                    s.mode = MODE_BLANK;
                end else if (c == qtl_pkg::CHAR_BACKSLASH) begin
                    s.mode = MODE_ESCAPE;
                end else begin
                    s.emit = 1'b1;
                    s.tok  = c;
                end
            end
            MODE_ESCAPE: begin
                s.emit = 1'b1;
                s.tok  = c;
                s.mode = MODE_QUOTED;
            end
            MODE_COMMENT: begin
                s.mode = MODE_COMMENT;
            end
            default: begin
                // Blank mode, and the unused codes which behave like it.
                if (qtl_pkg::is_word_char(c)) begin
                    s.emit = 1'b1;
                    s.tok  = c;
                    s.mode = MODE_WORD;
                end else if (c == qtl_pkg::CHAR_QUOTE) begin
                    s.mode = MODE_QUOTED;
                end else if (qtl_pkg::is_blank_char(c)) begin
                    s.mode = MODE_BLANK;
                end else if (c == qtl_pkg::CHAR_HASH) begin
                    s.mode = MODE_COMMENT;
                end else begin
                    s.mode = MODE_BLANK;
                    s.err  = 1'b1;
                end
            end
        endcase
        return s;
    endfunction

    byte_step_t       step;
    mode_t            mode_after;
    logic             err_after;
    logic             line_ok;
    qtl_pkg::result_t step_res;
    qtl_pkg::result_t final_res;

    always_comb begin
        // End of line is first handled as a newline byte.
        step = step_byte(mode_reg, (command == qtl_pkg::CMD_EOL) ? qtl_pkg::CHAR_LF : char_code);
        if (err_reg) begin
            step.emit = 1'b0;
            step.err  = 1'b0;
            step.mode = mode_reg;
        end
        mode_after = step.mode;
        err_after  = err_reg | step.err;
        line_ok    = !err_after && (mode_after == MODE_BLANK || mode_after == MODE_COMMENT);

        step_res.kind     = step.kind;
        step_res.tok_byte = step.tok;
        step_res.last     = (command != qtl_pkg::CMD_EOL);

        final_res.kind     = line_ok ? qtl_pkg::KIND_OK : qtl_pkg::KIND_ERR;
        final_res.tok_byte = 8'h00;
        final_res.last     = 1'b1;

        mode_next = mode_reg;
        err_next  = err_reg;
        res_cnt   = 2'd0;
        res0      = step_res;
        res1      = final_res;
        if (item_fire) begin
            if (command == qtl_pkg::CMD_EOL) begin
                mode_next = MODE_BLANK;
                err_next  = 1'b0;
                if (step.emit) begin
                    res_cnt = 2'd2;
                end else begin
                    res_cnt = 2'd1;
                    res0    = final_res;
                end
            end else begin
                mode_next = mode_after;
                err_next  = err_after;
                res_cnt   = {1'b0, step.emit};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_BLANK;
            err_reg  <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            err_reg  <= err_next;
        end
    end

endmodule

// File: hdl/qtl_out_fifo.sv
`timescale 1ns / 1ps

module qtl_out_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_cnt,
    input  qtl_pkg::result_t  push0,
    input  qtl_pkg::result_t  push1,
    input  logic              pop,
    output logic              not_empty,
    output logic              room_for_two,
    output qtl_pkg::result_t  head
);

    localparam int PtrW = $clog2(qtl_pkg::OutDepth);
    localparam int CntW = $clog2(qtl_pkg::OutDepth + 1);

    qtl_pkg::result_t mem_reg [qtl_pkg::OutDepth];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  wr_ptr_next;
    logic [PtrW-1:0]  wr_ptr_plus1;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_next;
    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  count_next;
    logic             do_pop;

    assign do_pop       = pop && (count_reg != '0);
    assign not_empty    = (count_reg != '0);
    assign room_for_two = (count_reg <= CntW'(qtl_pkg::OutDepth - 2));
    assign head         = mem_reg[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + PtrW'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PtrW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PtrW'(do_pop);
        count_next  = count_reg + CntW'(push_cnt) - CntW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/qtl_checker.sv
`timescale 1ns / 1ps

module qtl_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_kind,
    input logic [7:0] m_token_byte,
    input logic       m_last
);

    // A stalled result beat must not change under the consumer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_token_byte)
                                && $stable(m_last))
        else $error("result beat changed while stalled");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_kind <= qtl_pkg::KIND_ERR)
        else $error("result kind out of range");

    // Line status always closes the beats of an end-of-line item.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == qtl_pkg::KIND_OK || m_kind == qtl_pkg::KIND_ERR) |-> m_last)
        else $error("line status without last");

    a_drop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == qtl_pkg::KIND_DROP |-> m_last)
        else $error("dropped token marker without last");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != qtl_pkg::KIND_BYTE |-> m_token_byte == 8'h00)
        else $error("non-byte result carries a byte value");

endmodule

bind quoted_token_lexer_core qtl_checker u_qtl_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kind       (m_kind),
    .m_token_byte (m_token_byte),
    .m_last       (m_last)
);

// File: tb/sv/lexer_result_checker.sv
`timescale 1ns / 1ps

module lexer_result_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_char_code,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [2:0] m_kind,
    input  logic [7:0] m_token_byte,
    input  logic       m_last,
    output int         fail_count,
    output int         pending
);

    localparam logic [2:0] MODE_BLANK   = 3'd0;
    localparam logic [2:0] MODE_WORD    = 3'd1;
    localparam logic [2:0] MODE_QUOTED  = 3'd2;
    localparam logic [2:0] MODE_ESCAPE  = 3'd3;
    localparam logic [2:0] MODE_COMMENT = 3'd4;

    logic [2:0]        lex_state;
    logic              line_error;
    logic              token_open;
    int                mismatches;
    qtl_pkg::result_t  expected_q[$];

    function automatic logic token_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == qtl_pkg::CHAR_DOT ||
               c == qtl_pkg::CHAR_COLON || c == qtl_pkg::CHAR_EQUALS ||
               c == qtl_pkg::CHAR_SLASH || c == qtl_pkg::CHAR_MINUS ||
               c == qtl_pkg::CHAR_UNDER;
    endfunction

    function automatic logic space_char(input logic [7:0] c);
        return c == qtl_pkg::CHAR_SPACE || c == qtl_pkg::CHAR_TAB ||
               c == qtl_pkg::CHAR_CR || c == qtl_pkg::CHAR_LF;
    endfunction

    task automatic push_result(input qtl_pkg::kind_t k, input logic [7:0] b);
        qtl_pkg::result_t r;
        r.kind     = k;
        r.tok_byte = b;
        r.last     = 1'b0;
        expected_q.insert(expected_q.size(), r);
    endtask

    task automatic clear_line();
        lex_state  = MODE_BLANK;
        line_error = 1'b0;
        token_open = 1'b0;
    endtask

    // Once the line is in error every byte is swallowed until end of line.
    task automatic lex_char(input logic [7:0] c);
        if (!line_error) begin
            case (lex_state)
                MODE_WORD: begin
                    if (token_char(c)) begin
                        push_result(qtl_pkg::KIND_BYTE, c);
                    end else if (space_char(c)) begin
                        push_result(qtl_pkg::KIND_END, 8'h00);
                        token_open = 1'b0;
                        lex_state  = MODE_BLANK;
                    end else if (c == qtl_pkg::CHAR_HASH) begin
                        push_result(qtl_pkg::KIND_DROP, 8'h00);
                        token_open = 1'b0;
                        lex_state  = MODE_COMMENT;
                    end else begin
                        line_error = 1'b1;
                    end
                end
                MODE_QUOTED: begin
                    if (c == qtl_pkg::CHAR_QUOTE) begin
                        push_result(qtl_pkg::KIND_END, 8'h00);
                        token_open = 1'b0;
                        lex_state  = MODE_BLANK;
                    end else if (c == qtl_pkg::CHAR_BACKSLASH) begin
                        lex_state = MODE_ESCAPE;
                    end else begin
                        push_result(qtl_pkg::KIND_BYTE, c);
                    end
                end
                MODE_ESCAPE: begin
                    push_result(qtl_pkg::KIND_BYTE, c);
                    lex_state = MODE_QUOTED;
                end
                MODE_COMMENT: begin
                end
                default: begin
                    if (token_char(c)) begin
                        push_result(qtl_pkg::KIND_BYTE, c);
                        token_open = 1'b1;
                        lex_state  = MODE_WORD;
                    end else if (c == qtl_pkg::CHAR_QUOTE) begin
                        token_open = 1'b1;
                        lex_state  = MODE_QUOTED;
                    end else if (space_char(c)) begin
                        lex_state = MODE_BLANK;
                    end else if (c == qtl_pkg::CHAR_HASH) begin
                        lex_state = MODE_COMMENT;
                    end else begin
                        line_error = 1'b1;
                    end
                end
            endcase
        end
    endtask

    task automatic predict_beat(input logic cmd, input logic [7:0] c);
        int               q_size_at_start;
        qtl_pkg::result_t r;
        q_size_at_start = expected_q.size();
        if (cmd == qtl_pkg::CMD_CHAR) begin
            lex_char(c);
        end else begin
            // End of line behaves as a newline first, then gives the verdict.
            lex_char(qtl_pkg::CHAR_LF);
            if (!line_error && (lex_state == MODE_BLANK || lex_state == MODE_COMMENT)) begin
                push_result(qtl_pkg::KIND_OK, 8'h00);
            end else begin
                push_result(qtl_pkg::KIND_ERR, 8'h00);
            end
            clear_line();
        end
        if (expected_q.size() > q_size_at_start) begin
            r = expected_q[$];
            r.last = 1'b1;
            expected_q[$] = r;
        end
    endtask

    task automatic check_result();
        qtl_pkg::result_t r;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result beat: kind %0d byte %02h last %0b",
                     $time, m_kind, m_token_byte, m_last);
            mismatches++;
        end else begin
            r = expected_q.pop_front();
            if (m_kind !== r.kind || m_token_byte !== r.tok_byte || m_last !== r.last) begin
                $display("%0t: mismatch: expected kind %0d byte %02h last %0b, %s",
                         $time, r.kind, r.tok_byte, r.last, "got");
                $display("%0t:           got kind %0d byte %02h last %0b",
                         $time, m_kind, m_token_byte, m_last);
                mismatches++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_line();
            expected_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                predict_beat(s_command, s_char_code);
            end
            if (m_valid && m_ready) begin
                check_result();
            end
        end
        fail_count <= mismatches;
        pending    <= expected_q.size();
    end

endmodule

// File: tb/sv/tb_quoted_token_lexer_core.sv
`timescale 1ns / 1ps

module tb_quoted_token_lexer_core;

    localparam int CycleLimit = 400000;
    localparam int TotalItems = 775;

    logic       aclk;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_command   = qtl_pkg::CMD_CHAR;
    logic [7:0] s_char_code = 8'h00;
    logic       m_ready     = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [2:0] m_kind;
    logic [7:0] m_token_byte;
    logic       m_last;

    int fail_count;
    int pending;
    int items_sent;
    int idle_pct;
    int stall_left;
    int cycle_count;

    quoted_token_lexer_core u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_char_code  (s_char_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_token_byte (m_token_byte),
        .m_last       (m_last)
    );

    lexer_result_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_char_code  (s_char_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_token_byte (m_token_byte),
        .m_last       (m_last),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side stalls in bursts of random length.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (aresetn && $urandom_range(0, 99) < idle_pct) begin
            stall_left <= $urandom_range(0, 6);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(input logic cmd, input logic [7:0] c);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_char_code <= c;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_beat(qtl_pkg::CMD_CHAR, s[i]);
        end
    endtask

    function automatic logic [7:0] pick_word_char();
        int k;
        k = $urandom_range(0, 67);
        if (k < 26) return 8'(k) + 8'h41;
        if (k < 52) return 8'(k - 26) + 8'h61;
        if (k < 62) return 8'(k - 52) + 8'h30;
        case (k)
            62:      return qtl_pkg::CHAR_DOT;
            63:      return qtl_pkg::CHAR_COLON;
            64:      return qtl_pkg::CHAR_EQUALS;
            65:      return qtl_pkg::CHAR_SLASH;
            66:      return qtl_pkg::CHAR_MINUS;
            default: return qtl_pkg::CHAR_UNDER;
        endcase
    endfunction

    function automatic logic [7:0] pick_blank_char();
        case ($urandom_range(0, 3))
            0:       return qtl_pkg::CHAR_SPACE;
            1:       return qtl_pkg::CHAR_TAB;
            2:       return qtl_pkg::CHAR_CR;
            default: return qtl_pkg::CHAR_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_quoted_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == qtl_pkg::CHAR_QUOTE || b == qtl_pkg::CHAR_BACKSLASH);
        return b;
    endfunction

    // Mostly well-formed lines with random content; stray bytes and unclosed
    // quotes make up the rest.
    task automatic send_random_line();
        int n_tok;
        int style;
        n_tok = $urandom_range(0, 5);
        for (int t = 0; t < n_tok; t++) begin
            style = $urandom_range(0, 99);
            if (style < 45) begin
                repeat ($urandom_range(1, 6)) send_beat(qtl_pkg::CMD_CHAR, pick_word_char());
            end else if (style < 75) begin
                send_beat(qtl_pkg::CMD_CHAR, qtl_pkg::CHAR_QUOTE);
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_beat(qtl_pkg::CMD_CHAR, qtl_pkg::CHAR_BACKSLASH);
                        send_beat(qtl_pkg::CMD_CHAR, 8'($urandom_range(0, 255)));
                    end else begin
                        send_beat(qtl_pkg::CMD_CHAR, pick_quoted_byte());
                    end
                end
                if ($urandom_range(0, 9) != 0) begin
                    send_beat(qtl_pkg::CMD_CHAR, qtl_pkg::CHAR_QUOTE);
                end
            end else if (style < 85) begin
                send_beat(qtl_pkg::CMD_CHAR, qtl_pkg::CHAR_HASH);
                repeat ($urandom_range(0, 4)) begin
                    send_beat(qtl_pkg::CMD_CHAR, 8'($urandom_range(0, 255)));
                end
            end else begin
                send_beat(qtl_pkg::CMD_CHAR, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 99) < 85) begin
                repeat ($urandom_range(1, 2)) send_beat(qtl_pkg::CMD_CHAR, pick_blank_char());
            end
        end
        send_beat(qtl_pkg::CMD_EOL, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        idle_pct = 20;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Hash cutting a bare word, then a newline inside the comment.
        send_text("Z9#");
        send_beat(qtl_pkg::CMD_CHAR, qtl_pkg::CHAR_LF);
        send_beat(qtl_pkg::CMD_EOL, 8'h00);
        // Quoted bytes at both extremes and an escaped quote, left open.
        send_beat(qtl_pkg::CMD_CHAR, qtl_pkg::CHAR_QUOTE);
        send_beat(qtl_pkg::CMD_CHAR, 8'h00);
        send_beat(qtl_pkg::CMD_CHAR, qtl_pkg::CHAR_BACKSLASH);
        send_beat(qtl_pkg::CMD_CHAR, qtl_pkg::CHAR_QUOTE);
        send_beat(qtl_pkg::CMD_CHAR, 8'hFF);
        send_beat(qtl_pkg::CMD_EOL, 8'hFF);
        // End of line closing an open bare word.
        send_text("a.");
        send_beat(qtl_pkg::CMD_CHAR, qtl_pkg::CHAR_CR);
        send_text("_");
        send_beat(qtl_pkg::CMD_EOL, 8'h5A);
        // Closed quote, then end of line straight after a backslash.
        send_text("\"q\"\"\\");
        send_beat(qtl_pkg::CMD_EOL, 8'h00);
        // Quote inside a bare word, with bytes ignored after the error.
        send_text("b\"x");
        send_beat(qtl_pkg::CMD_EOL, 8'hA5);
        // Stray byte in blank mode.
        send_text("!");
        send_beat(qtl_pkg::CMD_EOL, 8'h00);

        while (items_sent < TotalItems) begin
            if (items_sent >= TotalItems - 120) begin
                idle_pct = 0;
            end else if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 3))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    2:       idle_pct = 25;
                    default: idle_pct = 50;
                endcase
            end
            send_random_line();
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/qtl_pkg.sv
hdl/qtl_lex.sv
hdl/qtl_out_fifo.sv
hdl/quoted_token_lexer_core.sv
hdl/qtl_checker.sv
tb/sv/lexer_result_checker.sv
tb/sv/tb_quoted_token_lexer_core.sv
